// ===== sv/avq_pkg.sv =====
// ----------------------------------------------------------------------------
// avq_pkg - shared definitions for the artificial viscosity block
// Pipeline depths, register indexes and the structs used by the datapath.
// ----------------------------------------------------------------------------
package avq_pkg;

    // Restoring divider for the squared sound speed: 68 quotient bits
    localparam int DIVA_STEPS = 68;
    // Square root: two radicand bits per step
    localparam int ROOT_STEPS = 32;
    // Radius fraction dividers: 32 quotient bits
    localparam int DIVB_STEPS = 32;
    // Square, product, difference stages after the radius dividers
    localparam int B_TAIL     = 3;

    // Stages after the second input stage until the threshold is ready
    localparam int A_LAT = DIVA_STEPS + ROOT_STEPS + 1;
    localparam int B_LAT = DIVB_STEPS + B_TAIL;
    // Delay line that lines up the divergence with the threshold
    localparam int ALIGN = A_LAT - B_LAT;
    // Total latency from request accept to result strobe
    localparam int LAT   = 2 + A_LAT + 6;

    // Register indexes
    localparam logic REG_VISC = 1'b0;
    localparam logic REG_THRC = 1'b1;

    // Configuration seen by the datapath
    typedef struct packed {
        logic [31:0] visc_sq;   // a^2, Q16.16
        logic [15:0] thr_coef;  // Q8.8
    } t_cfg;

    // Values riding along the radius dividers
    typedef struct packed {
        logic [32:0]        s;
        logic signed [31:0] u_o;
        logic signed [31:0] u_i;
        logic [63:0]        t1;
        logic               inv;
    } t_side;

    // Values riding along the alignment delay line
    typedef struct packed {
        logic signed [35:0] dv;
        logic [63:0]        t1;
        logic               inv;
    } t_tail;

endpackage

// ===== sv/avq_core.sv =====
// ----------------------------------------------------------------------------
// avq_core - artificial viscosity datapath
// Fully pipelined: dividers and square root one bit (pair) per stage,
// wide products split at bit 32 into partial products.
// ----------------------------------------------------------------------------
module avq_core import avq_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  t_cfg               i_cfg,
    input  logic [31:0]        i_radius_outer,
    input  logic [31:0]        i_radius_inner,
    input  logic signed [31:0] i_velocity_outer,
    input  logic signed [31:0] i_velocity_inner,
    input  logic [15:0]        i_adiabatic_gamma,
    input  logic [31:0]        i_pressure,
    input  logic [31:0]        i_density,
    output logic               o_strobe,
    output logic [47:0]        o_viscous_pressure,
    output logic               o_compressing,
    output logic               o_saturated,
    output logic               o_invalid_input
);

    // Valid bits, one per stage
    logic [LAT-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], i_start};
        end
    end

    // Stage 1: input capture
    logic [31:0]        r_s1_ro, r_s1_ri, r_s1_pres, r_s1_rho;
    logic signed [31:0] r_s1_uo, r_s1_ui;
    logic [15:0]        r_s1_gam;

    always_ff @(posedge i_clk) begin
        r_s1_ro   <= i_radius_outer;
        r_s1_ri   <= i_radius_inner;
        r_s1_uo   <= i_velocity_outer;
        r_s1_ui   <= i_velocity_inner;
        r_s1_gam  <= i_adiabatic_gamma;
        r_s1_pres <= i_pressure;
        r_s1_rho  <= i_density;
    end

    // Stage 2: gamma*P, radius sum, error check
    logic [47:0]        r_s2_num;
    logic [32:0]        r_s2_s;
    logic               r_s2_inv;
    logic [31:0]        r_s2_ro, r_s2_ri, r_s2_rho;
    logic signed [31:0] r_s2_uo, r_s2_ui;
    logic [32:0]        n_s2_s;

    assign n_s2_s = {1'b0, r_s1_ro} + {1'b0, r_s1_ri};

    always_ff @(posedge i_clk) begin
        r_s2_num <= 48'(r_s1_gam) * 48'(r_s1_pres);
        r_s2_s   <= n_s2_s;
        r_s2_inv <= (r_s1_rho == '0) || (n_s2_s == '0);
        r_s2_ro  <= r_s1_ro;
        r_s2_ri  <= r_s1_ri;
        r_s2_rho <= r_s1_rho;
        r_s2_uo  <= r_s1_uo;
        r_s2_ui  <= r_s1_ui;
    end

    // ------------------------------------------------------------------
    // Sound speed squared: floor(num * 2^20 / rho), one quotient bit a stage
    // ------------------------------------------------------------------
    logic [31:0] r_da_rem [DIVA_STEPS];
    logic [63:0] r_da_quo [DIVA_STEPS];
    logic        r_da_ovf [DIVA_STEPS];
    logic [47:0] r_da_num [DIVA_STEPS];
    logic [31:0] r_da_rho [DIVA_STEPS];

    for (genvar k = 0; k < DIVA_STEPS; k++) begin : g_diva
        logic [31:0] rem_in, rho_in;
        logic [63:0] quo_in;
        logic        ovf_in, dbit;
        logic [47:0] num_in;
        logic [32:0] cur;
        logic [33:0] dif;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign quo_in = '0;
            assign ovf_in = 1'b0;
            assign num_in = r_s2_num;
            assign rho_in = r_s2_rho;
        end else begin : g_next
            assign rem_in = r_da_rem[k-1];
            assign quo_in = r_da_quo[k-1];
            assign ovf_in = r_da_ovf[k-1];
            assign num_in = r_da_num[k-1];
            assign rho_in = r_da_rho[k-1];
        end

        // dividend bits below the 2^20 shift are zero
        if (k < 48) begin : g_bit
            assign dbit = num_in[47-k];
        end else begin : g_zero
            assign dbit = 1'b0;
        end

        assign cur = {rem_in, dbit};
        assign dif = {1'b0, cur} - {2'b00, rho_in};

        always_ff @(posedge i_clk) begin
            r_da_rem[k] <= dif[33] ? cur[31:0] : dif[31:0];
            r_da_quo[k] <= {quo_in[62:0], ~dif[33]};
            r_da_ovf[k] <= ovf_in | quo_in[63];
            r_da_num[k] <= num_in;
            r_da_rho[k] <= rho_in;
        end
    end

    // ------------------------------------------------------------------
    // Square root, two radicand bits a stage; clamps at 2^64-1 on overflow
    // ------------------------------------------------------------------
    logic [33:0] r_sq_rem  [ROOT_STEPS];
    logic [31:0] r_sq_root [ROOT_STEPS];
    logic [63:0] r_sq_rad  [ROOT_STEPS];

    for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_sqrt
        logic [33:0] rem_in;
        logic [31:0] root_in;
        logic [63:0] rad_in;
        logic [35:0] cur, trial, dif;
        logic        take;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = r_da_ovf[DIVA_STEPS-1] ? '1 : r_da_quo[DIVA_STEPS-1];
        end else begin : g_next
            assign rem_in  = r_sq_rem[k-1];
            assign root_in = r_sq_root[k-1];
            assign rad_in  = r_sq_rad[k-1];
        end

        assign cur   = {rem_in, rad_in[63-2*k -: 2]};
        assign trial = {2'b00, root_in, 2'b01};
        assign dif   = cur - trial;
        assign take  = (cur >= trial);

        always_ff @(posedge i_clk) begin
            r_sq_rem[k]  <= take ? dif[33:0] : cur[33:0];
            r_sq_root[k] <= {root_in[30:0], take};
            r_sq_rad[k]  <= rad_in;
        end
    end

    // Threshold = coefficient * c / 2^8
    logic [39:0] r_thr;
    logic [47:0] n_thr_prod;

    assign n_thr_prod = 48'(i_cfg.thr_coef) * 48'(r_sq_root[ROOT_STEPS-1]);

    always_ff @(posedge i_clk) begin
        r_thr <= n_thr_prod[47:8];
    end

    // ------------------------------------------------------------------
    // Radius fractions r*2^31/s, outer and inner side by side
    // ------------------------------------------------------------------
    logic [32:0] r_db_rem_o [DIVB_STEPS];
    logic [32:0] r_db_rem_i [DIVB_STEPS];
    logic [31:0] r_db_quo_o [DIVB_STEPS];
    logic [31:0] r_db_quo_i [DIVB_STEPS];
    t_side       r_db_side  [DIVB_STEPS];

    for (genvar k = 0; k < DIVB_STEPS; k++) begin : g_divb
        logic [32:0] rem_o_in, rem_i_in;
        logic [31:0] quo_o_in, quo_i_in;
        logic        bit_o, bit_i;
        t_side       side_in;
        logic [33:0] cur_o, cur_i;
        logic [34:0] dif_o, dif_i;

        if (k == 0) begin : g_first
            // dividend is r << 31: the top bits start the remainder
            assign rem_o_in      = {2'b00, r_s2_ro[31:1]};
            assign rem_i_in      = {2'b00, r_s2_ri[31:1]};
            assign quo_o_in      = '0;
            assign quo_i_in      = '0;
            assign bit_o         = r_s2_ro[0];
            assign bit_i         = r_s2_ri[0];
            assign side_in.s     = r_s2_s;
            assign side_in.u_o   = r_s2_uo;
            assign side_in.u_i   = r_s2_ui;
            assign side_in.t1    = 64'(i_cfg.visc_sq) * 64'(r_s2_rho);
            assign side_in.inv   = r_s2_inv;
        end else begin : g_next
            assign rem_o_in = r_db_rem_o[k-1];
            assign rem_i_in = r_db_rem_i[k-1];
            assign quo_o_in = r_db_quo_o[k-1];
            assign quo_i_in = r_db_quo_i[k-1];
            assign bit_o    = 1'b0;
            assign bit_i    = 1'b0;
            assign side_in  = r_db_side[k-1];
        end

        assign cur_o = {rem_o_in, bit_o};
        assign cur_i = {rem_i_in, bit_i};
        assign dif_o = {1'b0, cur_o} - {2'b00, side_in.s};
        assign dif_i = {1'b0, cur_i} - {2'b00, side_in.s};

        always_ff @(posedge i_clk) begin
            r_db_rem_o[k] <= dif_o[34] ? cur_o[32:0] : dif_o[32:0];
            r_db_rem_i[k] <= dif_i[34] ? cur_i[32:0] : dif_i[32:0];
            r_db_quo_o[k] <= {quo_o_in[30:0], ~dif_o[34]};
            r_db_quo_i[k] <= {quo_i_in[30:0], ~dif_i[34]};
            r_db_side[k]  <= side_in;
        end
    end

    // Squared fractions
    logic [31:0] r_w_o, r_w_i;
    t_side       r_w_side;
    logic [63:0] n_sq_o, n_sq_i;

    assign n_sq_o = 64'(r_db_quo_o[DIVB_STEPS-1]) * 64'(r_db_quo_o[DIVB_STEPS-1]);
    assign n_sq_i = 64'(r_db_quo_i[DIVB_STEPS-1]) * 64'(r_db_quo_i[DIVB_STEPS-1]);

    always_ff @(posedge i_clk) begin
        r_w_o    <= n_sq_o[62:31];
        r_w_i    <= n_sq_i[62:31];
        r_w_side <= r_db_side[DIVB_STEPS-1];
    end

    // Weighted velocities
    logic signed [63:0] r_x_o, r_x_i;
    t_side              r_x_side;
    logic signed [64:0] n_x_o, n_x_i;

    assign n_x_o = $signed({1'b0, r_w_o}) * r_w_side.u_o;
    assign n_x_i = $signed({1'b0, r_w_i}) * r_w_side.u_i;

    always_ff @(posedge i_clk) begin
        r_x_o    <= n_x_o[63:0];
        r_x_i    <= n_x_i[63:0];
        r_x_side <= r_w_side;
    end

    // Divergence = floor(diff / 2^29)
    t_tail              r_y;
    logic signed [64:0] n_diff;

    assign n_diff = {r_x_o[63], r_x_o} - {r_x_i[63], r_x_i};

    always_ff @(posedge i_clk) begin
        r_y.dv  <= n_diff[64:29];
        r_y.t1  <= r_x_side.t1;
        r_y.inv <= r_x_side.inv;
    end

    // Line up with the threshold
    t_tail r_dly [ALIGN];

    always_ff @(posedge i_clk) begin
        r_dly[0] <= r_y;
        for (int j = 1; j < ALIGN; j++) begin
            r_dly[j] <= r_dly[j-1];
        end
    end

    // ------------------------------------------------------------------
    // M = -(D + T); compressing when D + T < 0
    // ------------------------------------------------------------------
    logic signed [41:0] n_m;
    logic [35:0]        r_m_mm;
    logic [63:0]        r_m_t1;
    logic               r_m_comp, r_m_inv;

    assign n_m = 42'(r_dly[ALIGN-1].dv) + $signed({2'b00, r_thr});

    always_ff @(posedge i_clk) begin
        r_m_mm   <= 36'(-n_m);
        r_m_t1   <= r_dly[ALIGN-1].t1;
        r_m_comp <= n_m[41];
        r_m_inv  <= r_dly[ALIGN-1].inv;
    end

    // First product t1 * M: partial products
    logic [63:0] r_p1_ll, r_p1_hl;
    logic [35:0] r_p1_lh, r_p1_hh;
    logic [35:0] r_p1_mm;
    logic        r_p1_comp, r_p1_inv;

    always_ff @(posedge i_clk) begin
        r_p1_ll   <= 64'(r_m_t1[31:0])  * 64'(r_m_mm[31:0]);
        r_p1_hl   <= 64'(r_m_t1[63:32]) * 64'(r_m_mm[31:0]);
        r_p1_lh   <= 36'(r_m_t1[31:0])  * 36'(r_m_mm[35:32]);
        r_p1_hh   <= 36'(r_m_t1[63:32]) * 36'(r_m_mm[35:32]);
        r_p1_mm   <= r_m_mm;
        r_p1_comp <= r_m_comp;
        r_p1_inv  <= r_m_inv;
    end

    // First product sum; keep bits 95:32, overflow above 2^96
    logic [99:0] n_s1_sum;
    logic [63:0] r_s1_mid;
    logic        r_s1_sat;
    logic [35:0] r_s1_mm;
    logic        r_s1_comp, r_s1_inv;

    assign n_s1_sum = {36'b0, r_p1_ll} + {4'b0, r_p1_hl, 32'b0}
                    + {32'b0, r_p1_lh, 32'b0} + {r_p1_hh, 64'b0};

    always_ff @(posedge i_clk) begin
        r_s1_mid  <= n_s1_sum[95:32];
        r_s1_sat  <= |n_s1_sum[99:96];
        r_s1_mm   <= r_p1_mm;
        r_s1_comp <= r_p1_comp;
        r_s1_inv  <= r_p1_inv;
    end

    // Second product mid * M: partial products
    logic [63:0] r_p2_ll, r_p2_hl;
    logic [35:0] r_p2_lh, r_p2_hh;
    logic        r_p2_sat, r_p2_comp, r_p2_inv;

    always_ff @(posedge i_clk) begin
        r_p2_ll   <= 64'(r_s1_mid[31:0])  * 64'(r_s1_mm[31:0]);
        r_p2_hl   <= 64'(r_s1_mid[63:32]) * 64'(r_s1_mm[31:0]);
        r_p2_lh   <= 36'(r_s1_mid[31:0])  * 36'(r_s1_mm[35:32]);
        r_p2_hh   <= 36'(r_s1_mid[63:32]) * 36'(r_s1_mm[35:32]);
        r_p2_sat  <= r_s1_sat;
        r_p2_comp <= r_s1_comp;
        r_p2_inv  <= r_s1_inv;
    end

    // Second product sum; q0 = bits 63:16, overflow above 2^64
    logic [99:0] n_s2_sum;
    logic [47:0] r_q_val;
    logic        r_q_sat, r_q_comp, r_q_inv;

    assign n_s2_sum = {36'b0, r_p2_ll} + {4'b0, r_p2_hl, 32'b0}
                    + {32'b0, r_p2_lh, 32'b0} + {r_p2_hh, 64'b0};

    always_ff @(posedge i_clk) begin
        r_q_val  <= n_s2_sum[63:16];
        r_q_sat  <= r_p2_sat | (|n_s2_sum[99:64]);
        r_q_comp <= r_p2_comp;
        r_q_inv  <= r_p2_inv;
    end

    // Result register with the special cases
    logic [47:0] r_out_q0;
    logic        r_out_comp, r_out_sat, r_out_inv;

    always_ff @(posedge i_clk) begin
        if (r_q_inv) begin
            r_out_q0   <= '0;
            r_out_comp <= 1'b0;
            r_out_sat  <= 1'b0;
            r_out_inv  <= 1'b1;
        end else if (!r_q_comp) begin
            r_out_q0   <= '0;
            r_out_comp <= 1'b0;
            r_out_sat  <= 1'b0;
            r_out_inv  <= 1'b0;
        end else begin
            r_out_q0   <= r_q_sat ? '1 : r_q_val;
            r_out_comp <= 1'b1;
            r_out_sat  <= r_q_sat;
            r_out_inv  <= 1'b0;
        end
    end

    assign o_strobe           = r_vld[LAT-1];
    assign o_viscous_pressure = r_out_q0;
    assign o_compressing      = r_out_comp;
    assign o_saturated        = r_out_sat;
    assign o_invalid_input    = r_out_inv;

endmodule

// ===== sv/artificial_viscosity_q0_top.sv =====
// ----------------------------------------------------------------------------
// artificial_viscosity_q0_top - quadratic artificial viscosity per grid cell
// Register port plus the pipelined q0 datapath.
// ----------------------------------------------------------------------------
// Takes one cell request per clock with no gaps; busy never rises. Each
// request produces exactly one result, strobed for one cycle, in request
// order. The latency is set by the
// 68-stage restoring divider for c^2 = gamma*P/rho followed by the
// 32-stage square root; the divergence path runs alongside and is
// delayed to meet it. Results cannot be held off, so the receiver must
// take every strobe. The user must write registers over the APB port only
// while no request is in flight; the block itself does not enforce this.
module artificial_viscosity_q0_top import avq_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               start,
    output logic               busy,
    input  logic [31:0]        i_radius_outer,
    input  logic [31:0]        i_radius_inner,
    input  logic signed [31:0] i_velocity_outer,
    input  logic signed [31:0] i_velocity_inner,
    input  logic [15:0]        i_adiabatic_gamma,
    input  logic [31:0]        i_pressure,
    input  logic [31:0]        i_density,
    // result channel
    output logic               o_strobe,
    output logic [47:0]        o_viscous_pressure,
    output logic               o_compressing,
    output logic               o_saturated,
    output logic               o_invalid_input,
    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [15:0] r_visc, r_thrc;
    logic [31:0] r_visc_sq;
    logic        n_wr;
    t_cfg        cfg;

    assign n_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign busy   = 1'b0;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_visc <= 16'd512;
            r_thrc <= 16'd0;
        end else if (n_wr) begin
            case (paddr[2])
                REG_VISC: r_visc <= pwdata[15:0];
                REG_THRC: r_thrc <= pwdata[15:0];
                default:  r_visc <= r_visc;
            endcase
        end
    end

    // a^2 kept ready for the datapath
    always_ff @(posedge i_clk) begin
        r_visc_sq <= 32'(r_visc) * 32'(r_visc);
    end

    // Register reads
    always_comb begin
        case (paddr[2])
            REG_VISC: prdata = {16'b0, r_visc};
            REG_THRC: prdata = {16'b0, r_thrc};
            default:  prdata = '0;
        endcase
    end

    assign cfg.visc_sq  = r_visc_sq;
    assign cfg.thr_coef = r_thrc;

    avq_core u_core (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (start && !busy),
        .i_cfg              (cfg),
        .i_radius_outer     (i_radius_outer),
        .i_radius_inner     (i_radius_inner),
        .i_velocity_outer   (i_velocity_outer),
        .i_velocity_inner   (i_velocity_inner),
        .i_adiabatic_gamma  (i_adiabatic_gamma),
        .i_pressure         (i_pressure),
        .i_density          (i_density),
        .o_strobe           (o_strobe),
        .o_viscous_pressure (o_viscous_pressure),
        .o_compressing      (o_compressing),
        .o_saturated        (o_saturated),
        .o_invalid_input    (o_invalid_input)
    );

endmodule

// ===== sv/avq_checker.sv =====
// ----------------------------------------------------------------------------
// avq_checker - port-level checks for the artificial viscosity block
// Result flag consistency and request-to-result timing.
// ----------------------------------------------------------------------------
module avq_checker import avq_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_strobe,
    input logic [47:0]        o_viscous_pressure,
    input logic               o_compressing,
    input logic               o_saturated,
    input logic               o_invalid_input
);

    // an invalid cell reports nothing else
    a_inv_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_invalid_input) |->
            (o_viscous_pressure == '0 && !o_compressing && !o_saturated))
        else $error("invalid cell with nonzero result");

    // clipping only on a compressing cell, at full scale
    a_sat_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_saturated) |-> (o_compressing && o_viscous_pressure == '1))
        else $error("saturated result not at full scale");

    // no compression, no viscosity
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_compressing) |-> (o_viscous_pressure == '0))
        else $error("viscosity without compression");

    // every result traces back to an accepted request
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, LAT))
        else $error("result without matching request");

endmodule

bind artificial_viscosity_q0_top avq_checker u_avq_checker (.*);
